/* hdl/tlbcc_pkg.sv */
// Shared types, operation codes and widths for the compacting translation buffer.
package tlbcc_pkg;

    // Field widths of the beats
    localparam int OPCODE_W = 2;
    localparam int PAGE_W   = 32;
    localparam int FRAME_W  = 16;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_ENTRIES = 16;
    localparam int DEF_FRAME_BITS  = 16;

    // Capacity register reset value
    localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic live;      // cell index is below the entry count
        logic load;      // cell takes the new pair of an insert
        logic compact;   // a delete hit: cells at or past the match take the neighbor
    } t_cell_ctl;

endpackage

/* hdl/tlb_compacting_cam.sv */
// Top level of the compacting fully associative translation buffer.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per beat:
//   lookup, insert or delete of a page, with a frame for inserts.
//   Output channel (o_out_valid / i_out_ready) returns one result beat per
//   operation: hit, frame, status, entry count and full flag.
//   i_cfg_we / i_cfg_data set the capacity limit (values above the table
//   size act as the table size); write it only while the block is idle.
// Timing:
//   An operation accepted at one edge has its result on the output register
//   after that edge. All cells compare in parallel and a
//   delete shifts the later cells down in the same cycle, so one operation
//   per cycle is sustained while the receiver takes results.
//   When the receiver stalls, the held result blocks the next operation until
//   it is taken; o_in_ready is high when the output register is empty or
//   being emptied.
// Reset: entry count cleared, capacity back to 16, output empty. Entry
//   contents are not cleared; entries past the count are never matched.
module tlb_compacting_cam
    import tlbcc_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    parameter int FRAME_BITS  = DEF_FRAME_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [PAGE_W-1:0]   i_page,
    input  logic [FRAME_W-1:0]  i_frame_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_hit,
    output logic [FRAME_W-1:0]  o_frame_out,
    output logic [STATUS_W-1:0] o_status,
    output logic [COUNT_W-1:0]  o_entry_count,
    output logic                o_is_full
);

    localparam int SW = (FRAME_BITS < FRAME_W) ? FRAME_BITS : FRAME_W;
    localparam int IW = $clog2(MAX_ENTRIES) + 1;
    localparam int LW = (IW > COUNT_W) ? IW : COUNT_W;

    logic                r_out_valid;
    logic                r_hit;
    logic [SW-1:0]       r_frame;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count_out;
    logic                r_full;
    logic [COUNT_W-1:0]  r_cap_cfg;
    logic [COUNT_W-1:0]  r_count;
    logic [COUNT_W-1:0]  n_count;

    logic                accept;
    logic [LW-1:0]       cap;
    logic                at_cap;
    logic                hit_any;
    logic                do_insert;
    logic                do_delete;
    logic [SW-1:0]       new_frame;
    logic [STATUS_W-1:0] status;
    logic                res_hit;

    t_cell_ctl           cell_ctl   [MAX_ENTRIES];
    logic [PAGE_W-1:0]   cell_page  [MAX_ENTRIES];
    logic [SW-1:0]       cell_frame [MAX_ENTRIES];
    logic                found      [MAX_ENTRIES+1];
    logic [SW-1:0]       fchain     [MAX_ENTRIES+1];

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign new_frame  = i_frame_in[SW-1:0];

    // Effective capacity: saturate the register to the table size
    assign cap = (LW'(r_cap_cfg) > LW'(MAX_ENTRIES)) ? LW'(MAX_ENTRIES) : LW'(r_cap_cfg);
    assign at_cap = LW'(r_count) >= cap;

    assign hit_any   = found[MAX_ENTRIES];
    assign do_insert = accept && (i_opcode == OP_INSERT) && !at_cap;
    assign do_delete = accept && (i_opcode == OP_DELETE) && hit_any;

    // Row of cells
    assign found[0]  = 1'b0;
    assign fchain[0] = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign cell_ctl[g].live    = LW'(g) < LW'(r_count);
        assign cell_ctl[g].load    = do_insert && (LW'(g) == LW'(r_count));
        assign cell_ctl[g].compact = do_delete;

        tlbcc_cell #(
            .SW (SW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl[g]),
            .i_key         (i_page),
            .i_new_frame   (new_frame),
            .i_next_page   (cell_page[(g + 1 < MAX_ENTRIES) ? g + 1 : g]),
            .i_next_frame  (cell_frame[(g + 1 < MAX_ENTRIES) ? g + 1 : g]),
            .i_found       (found[g]),
            .i_frame_chain (fchain[g]),
            .o_page        (cell_page[g]),
            .o_frame       (cell_frame[g]),
            .o_found       (found[g+1]),
            .o_frame_chain (fchain[g+1])
        );
    end

    // Result status and next count
    always_comb begin
        n_count = r_count;
        status  = ST_DONE;
        res_hit = 1'b0;
        unique case (i_opcode)
            OP_LOOKUP: begin
                res_hit = hit_any;
                status  = hit_any ? ST_DONE : ST_MISS;
            end
            OP_INSERT: begin
                if (at_cap) begin
                    status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                res_hit = hit_any;
                if (hit_any) begin
                    n_count = r_count - 1'b1;
                end else begin
                    status = ST_MISS;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_cap_cfg   <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap_cfg <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit       <= res_hit;
            r_frame     <= (i_opcode == OP_LOOKUP) ? fchain[MAX_ENTRIES] : '0;
            r_status    <= status;
            r_count_out <= n_count;
            r_full      <= LW'(n_count) >= cap;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_hit;
    assign o_frame_out   = FRAME_W'(r_frame);
    assign o_status      = r_status;
    assign o_entry_count = r_count_out;
    assign o_is_full     = r_full;

endmodule

/* hdl/tlbcc_cell.sv */
// One entry of the buffer: holds a page/frame pair, compares and shifts down.
module tlbcc_cell
    import tlbcc_pkg::*;
#(
    parameter int SW = DEF_FRAME_BITS
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [PAGE_W-1:0] i_key,
    input  logic [SW-1:0]     i_new_frame,
    input  logic [PAGE_W-1:0] i_next_page,
    input  logic [SW-1:0]     i_next_frame,
    input  logic              i_found,
    input  logic [SW-1:0]     i_frame_chain,
    output logic [PAGE_W-1:0] o_page,
    output logic [SW-1:0]     o_frame,
    output logic              o_found,
    output logic [SW-1:0]     o_frame_chain
);

    logic [PAGE_W-1:0] r_page;
    logic [SW-1:0]     r_frame;
    logic              match;
    logic              first;

    // Compare and pass the first-match result along the row
    assign match         = i_ctl.live && (r_page == i_key);
    assign first         = match && !i_found;
    assign o_found       = i_found || match;
    assign o_frame_chain = first ? (i_frame_chain | r_frame) : i_frame_chain;

    assign o_page  = r_page;
    assign o_frame = r_frame;

    // Entry storage: insert load or compaction shift
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_page  <= i_key;
            r_frame <= i_new_frame;
        end else if (i_ctl.compact && o_found) begin
            r_page  <= i_next_page;
            r_frame <= i_next_frame;
        end
    end

endmodule
